@@ rtl/tild_pkg.sv @@
`default_nettype none
package tild_pkg;

  localparam int DEPTH_DEFAULT = 1024;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CH_CTL   = 8'd32;
  localparam logic [7:0] CH_OFS   = 8'd64;
  localparam logic [7:0] CH_CARET = 8'd94;

  // config register indexes
  localparam logic [7:0] REG_MODE  = 8'd0;
  localparam logic [7:0] REG_ERASE = 8'd1;
  localparam logic [7:0] REG_KILL  = 8'd2;
  localparam logic [7:0] REG_EOF   = 8'd3;
  localparam logic [7:0] REG_INTR  = 8'd4;
  localparam logic [7:0] REG_QUIT  = 8'd5;
  localparam logic [7:0] REG_START = 8'd6;
  localparam logic [7:0] REG_STOP  = 8'd7;

  // classes of a mapped received byte
  localparam logic [2:0] CLS_IGNORE = 3'd0;
  localparam logic [2:0] CLS_KILL   = 3'd1;
  localparam logic [2:0] CLS_ERASE  = 3'd2;
  localparam logic [2:0] CLS_STOP   = 3'd3;
  localparam logic [2:0] CLS_START  = 3'd4;
  localparam logic [2:0] CLS_INTR   = 3'd5;
  localparam logic [2:0] CLS_QUIT   = 3'd6;
  localparam logic [2:0] CLS_STORE  = 3'd7;

  // memory read address select
  localparam logic [1:0] RD_TAKE  = 2'd0;
  localparam logic [1:0] RD_LAST  = 2'd1;
  localparam logic [1:0] RD_LAST2 = 2'd2;

  typedef struct packed {
    logic       latch;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       reject;
    logic       set_stop;
    logic       clr_stop;
    logic       sig_intr;
    logic       sig_quit;
    logic       store;
    logic       pop;
    logic       erase_pop;
  } cmd_t;

  typedef struct packed {
    logic       is_take;
    logic       empty;
    logic       full;
    logic [2:0] cls;
    logic       rd_delim;
    logic       more;
  } stat_t;

endpackage
`default_nettype wire

@@ rtl/tild_ctrl.sv @@
`default_nettype none
module tild_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  output logic                out_valid,
  input  wire tild_pkg::stat_t st,
  output tild_pkg::cmd_t      cmd
);
  import tild_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_TAKE   = 3'd2;
  localparam logic [2:0] S_ERASE  = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_OUT;
        if (st.is_take) begin
          if (!st.empty) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_TAKE;
            state_nxt  = S_TAKE;
          end
        end else if (st.full) begin
          cmd.reject = 1'b1;
        end else begin
          case (st.cls)
            CLS_KILL, CLS_ERASE: begin
              if (!st.empty) begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_LAST;
                state_nxt  = S_ERASE;
              end
            end
            CLS_STOP:  cmd.set_stop = 1'b1;
            CLS_START: cmd.clr_stop = 1'b1;
            CLS_INTR:  cmd.sig_intr = 1'b1;
            CLS_QUIT:  cmd.sig_quit = 1'b1;
            CLS_STORE: cmd.store    = 1'b1;
            default: ;
          endcase
        end
      end
      S_TAKE: begin
        cmd.pop   = 1'b1;
        state_nxt = S_OUT;
      end
      S_ERASE: begin
        state_nxt = S_OUT;
        if (!st.rd_delim) begin
          cmd.erase_pop = 1'b1;
          // kill walks back one entry per cycle
          if (st.cls == CLS_KILL && st.more) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_LAST2;
            state_nxt  = S_ERASE;
          end
        end
      end
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/tild_dpath.sv @@
`default_nettype none
module tild_dpath #(
  parameter int LINE_DEPTH = tild_pkg::DEPTH_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_command,
  input  wire logic [7:0]      in_data_byte,
  input  wire logic            cfg_we,
  input  wire logic [7:0]      cfg_index,
  input  wire logic [7:0]      cfg_wdata,
  input  wire tild_pkg::cmd_t  cmd,
  output tild_pkg::stat_t      st,
  output logic                 out_accepted,
  output logic [1:0]           out_echo_count,
  output logic [7:0]           out_echo_first,
  output logic [7:0]           out_echo_second,
  output logic [10:0]          out_rubout_count,
  output logic [1:0]           out_signal_request,
  output logic                 out_output_stopped,
  output logic                 out_read_valid,
  output logic [7:0]           out_read_byte,
  output logic [9:0]           out_line_count,
  output logic [9:0]           out_fill_level
);
  import tild_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);
  localparam logic [AW-1:0] LAST = AW'(LINE_DEPTH - 1);

  logic [7:0] mode_r, erase_r, kill_r, eof_r, intr_r, quit_r, startc_r, stopc_r;
  logic [7:0] line_mem_r [LINE_DEPTH];
  logic [7:0] rd_data_r;
  logic [AW-1:0] wi_r, ri_r, cnt_r, dcnt_r;
  logic stop_r;
  logic take_r;
  logic [7:0] raw_r;
  logic acc_r, rv_r;
  logic [1:0] ecnt_r, sig_r;
  logic [7:0] e1_r, e2_r, rb_r;
  logic [10:0] rub_r;

  logic [7:0] c;
  logic ign;
  logic [2:0] cls;
  logic [AW-1:0] wi_prev, wi_prev2, ri_next, rd_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 8'd241; erase_r <= 8'd127; kill_r <= 8'd21; eof_r <= 8'd4;
      intr_r <= 8'd3; quit_r <= 8'd28; startc_r <= 8'd17; stopc_r <= 8'd19;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:  mode_r   <= cfg_wdata;
        REG_ERASE: erase_r  <= cfg_wdata;
        REG_KILL:  kill_r   <= cfg_wdata;
        REG_EOF:   eof_r    <= cfg_wdata;
        REG_INTR:  intr_r   <= cfg_wdata;
        REG_QUIT:  quit_r   <= cfg_wdata;
        REG_START: startc_r <= cfg_wdata;
        REG_STOP:  stopc_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input mapping and classification
  always_comb begin
    c   = raw_r;
    ign = 1'b0;
    if (raw_r == CH_CR) begin
      if (mode_r[0])      c   = CH_NL;
      else if (mode_r[1]) ign = 1'b1;
    end else if (raw_r == CH_NL && mode_r[2]) begin
      c = CH_CR;
    end
    if (mode_r[3] && c >= 8'd65 && c <= 8'd90) c = c + 8'd32;
    cls = CLS_STORE;
    if (ign)                              cls = CLS_IGNORE;
    else if (mode_r[4] && c == kill_r)    cls = CLS_KILL;
    else if (mode_r[4] && c == erase_r)   cls = CLS_ERASE;
    else if (mode_r[4] && c == stopc_r)   cls = CLS_STOP;
    else if (mode_r[4] && c == startc_r)  cls = CLS_START;
    else if (mode_r[5] && c == intr_r)    cls = CLS_INTR;
    else if (mode_r[5] && c == quit_r)    cls = CLS_QUIT;
  end

  assign wi_prev  = (wi_r == '0) ? LAST : wi_r - AW'(1);
  assign wi_prev2 = (wi_prev == '0) ? LAST : wi_prev - AW'(1);
  assign ri_next  = (ri_r == LAST) ? '0 : ri_r + AW'(1);

  always_comb begin
    case (cmd.rd_sel)
      RD_TAKE:  rd_addr = ri_r;
      RD_LAST:  rd_addr = wi_prev;
      RD_LAST2: rd_addr = wi_prev2;
      default:  rd_addr = ri_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rd_data_r <= line_mem_r[rd_addr];
    if (cmd.store) line_mem_r[wi_r] <= c;
  end

  assign st.is_take  = take_r;
  assign st.empty    = (cnt_r == '0);
  assign st.full     = (cnt_r == LAST);
  assign st.cls      = cls;
  assign st.rd_delim = (rd_data_r == CH_NL) || (rd_data_r == eof_r);
  assign st.more     = (cnt_r > AW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wi_r <= '0; ri_r <= '0; cnt_r <= '0; dcnt_r <= '0; stop_r <= 1'b0;
    end else begin
      if (cmd.set_stop) stop_r <= 1'b1;
      if (cmd.clr_stop) stop_r <= 1'b0;
      if (cmd.store) begin
        wi_r  <= (wi_r == LAST) ? '0 : wi_r + AW'(1);
        cnt_r <= cnt_r + AW'(1);
        if ((c == CH_NL || c == eof_r) && dcnt_r != LAST) dcnt_r <= dcnt_r + AW'(1);
      end
      if (cmd.pop) begin
        ri_r  <= ri_next;
        cnt_r <= cnt_r - AW'(1);
        if (st.rd_delim && dcnt_r != '0) dcnt_r <= dcnt_r - AW'(1);
      end
      if (cmd.erase_pop) begin
        wi_r  <= wi_prev;
        cnt_r <= cnt_r - AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      take_r <= in_command;
      raw_r  <= in_data_byte;
      acc_r  <= 1'b1; ecnt_r <= 2'd0; e1_r <= 8'd0; e2_r <= 8'd0;
      rub_r  <= 11'd0; sig_r <= 2'd0; rv_r <= 1'b0; rb_r <= 8'd0;
    end
    if (cmd.reject)   acc_r <= 1'b0;
    if (cmd.sig_intr) sig_r <= 2'd1;
    if (cmd.sig_quit) sig_r <= 2'd2;
    if (cmd.pop) begin
      rv_r <= 1'b1;
      rb_r <= rd_data_r;
    end
    if (cmd.erase_pop && mode_r[6])
      rub_r <= rub_r + ((rd_data_r < CH_CTL) ? 11'd2 : 11'd1);
    if (cmd.store && mode_r[6]) begin
      if (c == CH_NL) begin
        ecnt_r <= 2'd2; e1_r <= CH_NL; e2_r <= CH_CR;
      end else if (c < CH_CTL) begin
        if (mode_r[7]) begin
          ecnt_r <= 2'd2; e1_r <= CH_CARET; e2_r <= c + CH_OFS;
        end
      end else begin
        ecnt_r <= 2'd1; e1_r <= c;
      end
    end
  end

  assign out_accepted       = acc_r;
  assign out_echo_count     = ecnt_r;
  assign out_echo_first     = e1_r;
  assign out_echo_second    = e2_r;
  assign out_rubout_count   = rub_r;
  assign out_signal_request = sig_r;
  assign out_output_stopped = stop_r;
  assign out_read_valid     = rv_r;
  assign out_read_byte      = rb_r;
  assign out_line_count     = 10'(dcnt_r);
  assign out_fill_level     = 10'(cnt_r);

endmodule
`default_nettype wire

@@ rtl/tty_input_line_discipline_core.sv @@
// terminal input line discipline
// command channel: pulse start with in_command/in_data_byte while busy is low;
// in_command 0 offers a raw byte, 1 takes one cooked byte from the line store.
// busy rises on the next edge and stays high through the result cycle.
// the result appears on the out_ ports for exactly one cycle with out_valid;
// there is no back pressure, the receiver must take it in that cycle.
// most commands pass through latch, decode and result; a take or an erase on
// a non-empty store adds a take or erase step before the result, and a kill
// repeats its erase step, removing bytes until it empties the store or stops at
// a line boundary; the kill walk is bounded by the single read port of the line
// store, one entry per cycle. one command is in flight at a time.
// config port: cfg_valid/cfg_index/cfg_wdata, always ready; write only while
// busy is low. indexes 0..7 select mode, erase, kill, eof, intr, quit, start,
// stop; other indexes are ignored.
// reset (rst_n low, synchronous) empties the store, clears line count and
// stopped flag and loads the default control characters; the store contents
// themselves are not cleared and need no clearing pass.
`default_nettype none
module tty_input_line_discipline_core #(
  parameter int LINE_DEPTH = tild_pkg::DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_command,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  output logic             out_accepted,
  output logic [1:0]       out_echo_count,
  output logic [7:0]       out_echo_first,
  output logic [7:0]       out_echo_second,
  output logic [10:0]      out_rubout_count,
  output logic [1:0]       out_signal_request,
  output logic             out_output_stopped,
  output logic             out_read_valid,
  output logic [7:0]       out_read_byte,
  output logic [9:0]       out_line_count,
  output logic [9:0]       out_fill_level,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata
);
  import tild_pkg::*;

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  tild_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .st        (st),
    .cmd       (cmd)
  );

  tild_dpath #(.LINE_DEPTH(LINE_DEPTH)) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_command         (in_command),
    .in_data_byte       (in_data_byte),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .cmd                (cmd),
    .st                 (st),
    .out_accepted       (out_accepted),
    .out_echo_count     (out_echo_count),
    .out_echo_first     (out_echo_first),
    .out_echo_second    (out_echo_second),
    .out_rubout_count   (out_rubout_count),
    .out_signal_request (out_signal_request),
    .out_output_stopped (out_output_stopped),
    .out_read_valid     (out_read_valid),
    .out_read_byte      (out_read_byte),
    .out_line_count     (out_line_count),
    .out_fill_level     (out_fill_level)
  );

endmodule
`default_nettype wire

@@ rtl/tild_checker.sv @@
`default_nettype none
module tild_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic       out_accepted,
  input wire logic       out_read_valid,
  input wire logic [7:0] out_read_byte
);

  // a transaction result is a single-cycle strobe
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised after start");

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result shown while idle");

  a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_read_valid) |-> (out_read_byte == 8'd0))
    else $error("read byte not zero without read");

  a_read_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_read_valid) |-> out_accepted)
    else $error("read returned on a rejected transaction");

endmodule

bind tty_input_line_discipline_core tild_checker u_tild_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_accepted   (out_accepted),
  .out_read_valid (out_read_valid),
  .out_read_byte  (out_read_byte)
);
`default_nettype wire

@@ tb/tty_input_line_discipline_core_tb.sv @@
`default_nettype none
module tty_input_line_discipline_core_tb;
  import tild_pkg::*;

  localparam int DEPTH = 1024;
  localparam int STALL_LIMIT = 8000;

  localparam logic CMD_RECEIVE = 1'b0;
  localparam logic CMD_TAKE    = 1'b1;

  localparam int MB_CRNL  = 0;
  localparam int MB_IGNCR = 1;
  localparam int MB_NLCR  = 2;
  localparam int MB_LOWER = 3;
  localparam int MB_CANON = 4;
  localparam int MB_SIG   = 5;
  localparam int MB_ECHO  = 6;
  localparam int MB_ECTL  = 7;

  localparam logic [1:0] SIG_NONE = 2'd0;
  localparam logic [1:0] SIG_INTR = 2'd1;
  localparam logic [1:0] SIG_QUIT = 2'd2;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  echo_count;
    logic [7:0]  echo_first;
    logic [7:0]  echo_second;
    logic [10:0] rubout_count;
    logic [1:0]  signal_request;
    logic        output_stopped;
    logic        read_valid;
    logic [7:0]  read_byte;
    logic [9:0]  line_count;
    logic [9:0]  fill_level;
  } cooked_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic in_command = 1'b0;
  logic [7:0] in_data_byte = 8'd0;
  logic cfg_valid = 1'b0;
  logic [7:0] cfg_index = 8'd0;
  logic [7:0] cfg_wdata = 8'd0;
  wire busy, out_valid, out_accepted, out_output_stopped, out_read_valid, cfg_ready;
  wire [1:0] out_echo_count, out_signal_request;
  wire [7:0] out_echo_first, out_echo_second, out_read_byte;
  wire [10:0] out_rubout_count;
  wire [9:0] out_line_count, out_fill_level;

  tty_input_line_discipline_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_accepted(out_accepted),
    .out_echo_count(out_echo_count), .out_echo_first(out_echo_first),
    .out_echo_second(out_echo_second), .out_rubout_count(out_rubout_count),
    .out_signal_request(out_signal_request), .out_output_stopped(out_output_stopped),
    .out_read_valid(out_read_valid), .out_read_byte(out_read_byte),
    .out_line_count(out_line_count), .out_fill_level(out_fill_level),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [7:0] line_mem [DEPTH];
  int wr_ptr, rd_ptr, held, lines;
  logic stopped;
  logic [7:0] mode, c_erase, c_kill, c_eof, c_intr, c_quit, c_start, c_stop;

  cooked_t pending_results[$];
  int errors = 0;
  int idle_cycles = 0;

  function automatic int ptr_prev(int i);
    return (i == 0) ? DEPTH - 1 : i - 1;
  endfunction

  function automatic bit delim(logic [7:0] c);
    return c == CH_NL || c == c_eof;
  endfunction

  // removes the last byte of the current line; returns rubouts, flags removal
  function automatic int erase_last(output bit removed);
    logic [7:0] last;
    removed = 0;
    if (held == 0) return 0;
    last = line_mem[ptr_prev(wr_ptr)];
    if (delim(last)) return 0;
    wr_ptr = ptr_prev(wr_ptr);
    held--;
    removed = 1;
    if (!mode[MB_ECHO]) return 0;
    return (last < CH_CTL) ? 2 : 1;
  endfunction

  function automatic cooked_t cook(logic cmd, logic [7:0] raw);
    cooked_t r;
    logic [7:0] c;
    bit done, removed;
    int rub;
    r = '0;
    r.accepted = 1'b1;
    rub = 0;
    done = 0;
    c = raw;
    if (cmd == CMD_TAKE) begin
      if (held > 0) begin
        r.read_byte = line_mem[rd_ptr];
        r.read_valid = 1'b1;
        rd_ptr = (rd_ptr + 1) % DEPTH;
        held--;
        if (delim(r.read_byte) && lines > 0) lines--;
      end
    end else if (held >= DEPTH - 1) begin
      r.accepted = 1'b0;
    end else begin
      if (c == CH_CR) begin
        if (mode[MB_CRNL]) c = CH_NL;
        else if (mode[MB_IGNCR]) done = 1;
      end else if (c == CH_NL && mode[MB_NLCR]) begin
        c = CH_CR;
      end
      if (!done && mode[MB_LOWER] && c >= 8'd65 && c <= 8'd90) c = c + 8'd32;
      if (!done && mode[MB_CANON]) begin
        if (c == c_kill) begin
          do rub += erase_last(removed); while (removed);
          done = 1;
        end else if (c == c_erase) begin
          rub += erase_last(removed);
          done = 1;
        end else if (c == c_stop) begin
          stopped = 1'b1;
          done = 1;
        end else if (c == c_start) begin
          stopped = 1'b0;
          done = 1;
        end
      end
      if (!done && mode[MB_SIG]) begin
        if (c == c_intr) begin
          r.signal_request = SIG_INTR;
          done = 1;
        end else if (c == c_quit) begin
          r.signal_request = SIG_QUIT;
          done = 1;
        end
      end
      if (!done) begin
        if (delim(c) && lines < DEPTH - 1) lines++;
        if (mode[MB_ECHO]) begin
          if (c == CH_NL) begin
            r.echo_count = 2'd2; r.echo_first = CH_NL; r.echo_second = CH_CR;
          end else if (c < CH_CTL) begin
            if (mode[MB_ECTL]) begin
              r.echo_count = 2'd2; r.echo_first = CH_CARET; r.echo_second = c + CH_OFS;
            end
          end else begin
            r.echo_count = 2'd1; r.echo_first = c;
          end
        end
        line_mem[wr_ptr] = c;
        wr_ptr = (wr_ptr + 1) % DEPTH;
        held++;
      end
    end
    r.rubout_count = rub[10:0];
    r.output_stopped = stopped;
    r.line_count = lines[9:0];
    r.fill_level = held[9:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_cmd(logic cmd, logic [7:0] data);
    start <= 1'b1;
    in_command <= cmd;
    in_data_byte <= data;
    do @(posedge clk); while (busy);
    pending_results.push_back(cook(cmd, data));
    start <= 1'b0;
    in_command <= 1'($urandom_range(0, 1));
    in_data_byte <= rand_byte();
    @(posedge clk);
    repeat (pick_gap()) @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODE:  mode = val;
      REG_ERASE: c_erase = val;
      REG_KILL:  c_kill = val;
      REG_EOF:   c_eof = val;
      REG_INTR:  c_intr = val;
      REG_QUIT:  c_quit = val;
      REG_START: c_start = val;
      REG_STOP:  c_stop = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(logic [7:0] m, logic [7:0] er, logic [7:0] kl, logic [7:0] ef,
                           logic [7:0] it, logic [7:0] qt, logic [7:0] st, logic [7:0] sp);
    wait_drained();
    write_reg(REG_MODE, m);
    write_reg(REG_ERASE, er);
    write_reg(REG_KILL, kl);
    write_reg(REG_EOF, ef);
    write_reg(REG_INTR, it);
    write_reg(REG_QUIT, qt);
    write_reg(REG_START, st);
    write_reg(REG_STOP, sp);
  endtask

  function automatic logic [7:0] pick_byte();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return rand_byte();
    if (p < 65) return 8'($urandom_range(65, 122));
    case ($urandom_range(0, 8))
      0: return CH_CR;
      1: return CH_NL;
      2: return c_erase;
      3: return c_kill;
      4: return c_eof;
      5: return c_intr;
      6: return c_quit;
      7: return c_start;
      default: return c_stop;
    endcase
  endfunction

  task automatic run_random(int n, int take_pct);
    repeat (n) begin
      if ($urandom_range(0, 99) < take_pct) send_cmd(CMD_TAKE, rand_byte());
      else send_cmd(CMD_RECEIVE, pick_byte());
    end
  endtask

  task automatic test_default_chars();
    logic [7:0] seq [$];
    seq = '{8'h61, 8'h42, 8'h01, CH_CR, 8'h80, 8'hFF, 8'd127, 8'h78, 8'd21, 8'h79,
            8'd19, 8'd17, 8'd3, 8'd28, 8'd4, 8'h00, CH_NL, 8'd21, 8'd127, 8'h20};
    send_cmd(CMD_TAKE, 8'hFF);
    foreach (seq[i]) send_cmd(CMD_RECEIVE, seq[i]);
    repeat (4) send_cmd(CMD_TAKE, 8'h00);
  endtask

  task automatic test_extreme_settings();
    write_all(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    run_random(120, 30);
    write_all(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    run_random(120, 30);
    // cr ignored, nl mapped to cr, no echo of control bytes
    write_all(8'h76, 8'd8, 8'd21, 8'd4, 8'd3, 8'd28, 8'd17, 8'd19);
    run_random(120, 30);
  endtask

  task automatic test_random_settings();
    repeat (4) begin
      write_all(rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                rand_byte(), rand_byte(), rand_byte(), rand_byte());
      run_random(110, 35);
    end
  endtask

  // raw mode so every byte lands in the store, then push past full
  task automatic test_store_full();
    write_all(8'h40, 8'd127, 8'd21, 8'd4, 8'd3, 8'd28, 8'd17, 8'd19);
    repeat (DEPTH + 6) send_cmd(CMD_RECEIVE, rand_byte());
    run_random(60, 50);
    // canonical again so a kill walks back across a long line
    write_all(8'hF1, 8'd127, 8'd21, 8'd4, 8'd3, 8'd28, 8'd17, 8'd19);
    send_cmd(CMD_RECEIVE, 8'd21);
    run_random(100, 40);
  endtask

  always @(posedge clk) begin
    cooked_t want, got;
    if (rst_n && out_valid) begin
      got = '{out_accepted, out_echo_count, out_echo_first, out_echo_second,
              out_rubout_count, out_signal_request, out_output_stopped,
              out_read_valid, out_read_byte, out_line_count, out_fill_level};
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result exp none got %h", $time, got);
      end else begin
        want = pending_results.pop_front();
        if (got.accepted != want.accepted)
          $display("%0t: accepted exp %0d got %0d", $time, want.accepted, got.accepted);
        if (got.echo_count != want.echo_count)
          $display("%0t: echo_count exp %0d got %0d", $time, want.echo_count, got.echo_count);
        if (got.echo_first != want.echo_first)
          $display("%0t: echo_first exp %0d got %0d", $time, want.echo_first, got.echo_first);
        if (got.echo_second != want.echo_second)
          $display("%0t: echo_second exp %0d got %0d", $time, want.echo_second,
                   got.echo_second);
        if (got.rubout_count != want.rubout_count)
          $display("%0t: rubout_count exp %0d got %0d", $time, want.rubout_count,
                   got.rubout_count);
        if (got.signal_request != want.signal_request)
          $display("%0t: signal_request exp %0d got %0d", $time, want.signal_request,
                   got.signal_request);
        if (got.output_stopped != want.output_stopped)
          $display("%0t: output_stopped exp %0d got %0d", $time, want.output_stopped,
                   got.output_stopped);
        if (got.read_valid != want.read_valid)
          $display("%0t: read_valid exp %0d got %0d", $time, want.read_valid, got.read_valid);
        if (got.read_byte != want.read_byte)
          $display("%0t: read_byte exp %0d got %0d", $time, want.read_byte, got.read_byte);
        if (got.line_count != want.line_count)
          $display("%0t: line_count exp %0d got %0d", $time, want.line_count, got.line_count);
        if (got.fill_level != want.fill_level)
          $display("%0t: fill_level exp %0d got %0d", $time, want.fill_level, got.fill_level);
        if (got != want) errors++;
      end
    end
  end

  // watchdog on cycles with no transaction of any kind
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wr_ptr = 0; rd_ptr = 0; held = 0; lines = 0; stopped = 1'b0;
    mode = 8'd241; c_erase = 8'd127; c_kill = 8'd21; c_eof = 8'd4;
    c_intr = 8'd3; c_quit = 8'd28; c_start = 8'd17; c_stop = 8'd19;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_chars();
    test_extreme_settings();
    test_random_settings();
    test_store_full();
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ tty_input_line_discipline_core.f @@
rtl/tild_pkg.sv
rtl/tild_ctrl.sv
rtl/tild_dpath.sv
rtl/tty_input_line_discipline_core.sv
rtl/tild_checker.sv
tb/tty_input_line_discipline_core_tb.sv
